FILE: rtl/mrpt_pkg.sv
// Package for the 64-bit Miller-Rabin prime test unit.
// Holds the verdict codes, the witness base table and the mulmod control struct.
// Depends on nothing.
`timescale 1ns / 1ps
package mrpt_pkg;
   localparam int NumBases = 12;
   localparam logic [2:0] DecBelowTwo   = 3'd0;
   localparam logic [2:0] DecEqualsBase = 3'd1;
   localparam logic [2:0] DecBaseDivides = 3'd2;
   localparam logic [2:0] DecWitnessFails = 3'd3;
   localparam logic [2:0] DecAllPass    = 3'd4;

   function automatic logic [5:0] base_at(input logic [3:0] idx);
      case (idx)
         4'd0: base_at = 6'd2;
         4'd1: base_at = 6'd3;
         4'd2: base_at = 6'd5;
         4'd3: base_at = 6'd7;
         4'd4: base_at = 6'd11;
         4'd5: base_at = 6'd13;
         4'd6: base_at = 6'd17;
         4'd7: base_at = 6'd19;
         4'd8: base_at = 6'd23;
         4'd9: base_at = 6'd29;
         4'd10: base_at = 6'd31;
         4'd11: base_at = 6'd37;
         default: base_at = 6'd0;
      endcase
   endfunction

   typedef struct packed {
      logic start;
      logic done;
   } mm_ctl_type;
endpackage

FILE: rtl/miller_rabin_prime_test_64_unit.sv
// Deterministic 64-bit Miller-Rabin prime test, top level.
// Depends on mrpt_pkg and mrpt_mulmod.
//
// Usage:
//  - req_valid/req_ready carry one 64-bit candidate, req_number, per transfer.
//  - rsp_valid/rsp_ready carry the verdict: rsp_is_prime, rsp_decided_by
//    (0 below two, 1 equals base, 2 base divides, 3 witness fails, 4 all pass)
//    and rsp_deciding_base.
//  - One candidate is in work at a time. Trial division by the twelve bases
//    runs bit-serially.
//  - Each Miller-Rabin round runs a square-and-multiply exponentiation on
//    the shared bit-serial modular multiplier, one multiplier bit per cycle.
//    A full prime verdict runs all twelve rounds; composites usually stop
//    at the first witness.
//  - The verdict sits in an output register; a stalled receiver holds it,
//    and the next candidate is taken once the verdict has been transferred.
//  - Synchronous reset returns to idle with no result pending.
`timescale 1ns / 1ps
module miller_rabin_prime_test_64_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_prime,
   output logic [2:0]  rsp_decided_by,
   output logic [5:0]  rsp_deciding_base
);
   import mrpt_pkg::*;

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StCheck  = 4'd1;  // equality test for current base
   localparam logic [3:0] StDiv    = 4'd2;  // serial remainder by current base
   localparam logic [3:0] StSplit  = 4'd3;  // strip trailing zeros of n-1
   localparam logic [3:0] StExpBit = 4'd4;  // exponent bit: decide multiply
   localparam logic [3:0] StMulAcc = 4'd5;  // wait acc*base
   localparam logic [3:0] StMulSq  = 4'd6;  // wait base*base
   localparam logic [3:0] StTest   = 4'd7;  // check x after exponentiation
   localparam logic [3:0] StSqr    = 4'd8;  // wait x*x
   localparam logic [3:0] StOut    = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] d_ff, d_in;       // odd part of n-1
   logic [6:0]  r_ff, r_in;
   logic [6:0]  k_ff, k_in;
   logic [3:0]  bi_ff, bi_in;     // base index
   logic [63:0] sh_ff, sh_in;     // shift register: dividend bits or exponent bits
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  rem_ff, rem_in;
   logic [63:0] acc_ff, acc_in, bs_ff, bs_in;
   logic        o_prime_ff, o_prime_in;
   logic [2:0]  o_dec_ff, o_dec_in;
   logic [5:0]  o_base_ff, o_base_in;

   logic        mm_start;
   logic [63:0] mm_x, mm_y, mm_p;
   mm_ctl_type  mm_ctl;

   logic [5:0]  cur_base;
   logic [6:0]  rem_sh;
   logic [63:0] n_m1;

   assign cur_base = base_at(bi_ff);
   assign rem_sh   = {rem_ff, sh_ff[63]};
   assign n_m1     = n_ff - 64'd1;

   mrpt_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_x    (mm_x),
      .op_y    (mm_y),
      .modulus (n_ff),
      .ctl     (mm_ctl),
      .product (mm_p)
   );

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      r_in       = r_ff;
      k_in       = k_ff;
      bi_in      = bi_ff;
      sh_in      = sh_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      bs_in      = bs_ff;
      o_prime_in = o_prime_ff;
      o_dec_in   = o_dec_ff;
      o_base_in  = o_base_ff;
      mm_start   = 1'b0;
      mm_x       = acc_ff;
      mm_y       = bs_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               n_in  = req_number;
               bi_in = 4'd0;
               if (req_number < 64'd2) begin
                  o_prime_in = 1'b0;
                  o_dec_in   = DecBelowTwo;
                  o_base_in  = 6'd0;
                  state_in   = StOut;
               end else begin
                  state_in = StCheck;
               end
            end
         end
         StCheck: begin
            if (n_ff == {58'd0, cur_base}) begin
               o_prime_in = 1'b1;
               o_dec_in   = DecEqualsBase;
               o_base_in  = cur_base;
               state_in   = StOut;
            end else begin
               sh_in    = n_ff;
               rem_in   = 6'd0;
               cnt_in   = 7'd0;
               state_in = StDiv;
            end
         end
         StDiv: begin
            // one dividend bit a cycle, remainder stays below the base
            if (rem_sh >= {1'b0, cur_base}) begin
               rem_in = 6'(rem_sh - {1'b0, cur_base});
            end else begin
               rem_in = rem_sh[5:0];
            end
            sh_in  = {sh_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               if (rem_in == 6'd0) begin
                  o_prime_in = 1'b0;
                  o_dec_in   = DecBaseDivides;
                  o_base_in  = cur_base;
                  state_in   = StOut;
               end else if (bi_ff == 4'(NumBases - 1)) begin
                  d_in     = n_m1;
                  r_in     = 7'd0;
                  state_in = StSplit;
               end else begin
                  bi_in    = bi_ff + 4'd1;
                  state_in = StCheck;
               end
            end
         end
         StSplit: begin
            if (!d_ff[0] && r_ff < 7'd64) begin
               d_in = {1'b0, d_ff[63:1]};
               r_in = r_ff + 7'd1;
            end else begin
               bi_in    = 4'd0;
               acc_in   = 64'd1;
               bs_in    = {58'd0, base_at(4'd0)};
               sh_in    = d_ff;
               state_in = StExpBit;
            end
         end
         StExpBit: begin
            // base is below every n reaching here (n > 37), so no reduction
            if (sh_ff == 64'd0) begin
               state_in = StTest;
            end else if (sh_ff[0]) begin
               mm_start = 1'b1;
               state_in = StMulAcc;
            end else begin
               mm_start = 1'b1;
               mm_x     = bs_ff;
               state_in = StMulSq;
            end
         end
         StMulAcc: begin
            if (mm_ctl.done) begin
               acc_in   = mm_p;
               mm_start = 1'b1;
               mm_x     = bs_ff;
               state_in = StMulSq;
            end
         end
         StMulSq: begin
            mm_x = bs_ff;
            if (mm_ctl.done) begin
               bs_in    = mm_p;
               sh_in    = {1'b0, sh_ff[63:1]};
               state_in = StExpBit;
            end
         end
         StTest: begin
            if (acc_ff == 64'd1 || acc_ff == n_m1) begin
               state_in = StOut;  // provisional; resolved below
            end else begin
               k_in = 7'd1;
               state_in = StSqr;
               if (r_ff > 7'd1) begin
                  mm_start = 1'b1;
                  mm_y     = acc_ff;
               end
            end
            if (state_in == StOut || (state_in == StSqr && r_ff <= 7'd1)) begin
               if (state_in == StSqr) begin
                  o_prime_in = 1'b0;
                  o_dec_in   = DecWitnessFails;
                  o_base_in  = cur_base;
                  state_in   = StOut;
               end else if (bi_ff == 4'(NumBases - 1)) begin
                  o_prime_in = 1'b1;
                  o_dec_in   = DecAllPass;
                  o_base_in  = 6'd0;
                  state_in   = StOut;
               end else begin
                  bi_in    = bi_ff + 4'd1;
                  acc_in   = 64'd1;
                  bs_in    = {58'd0, base_at(bi_ff + 4'd1)};
                  sh_in    = d_ff;
                  state_in = StExpBit;
               end
            end
         end
         StSqr: begin
            mm_y = acc_ff;
            if (mm_ctl.done) begin
               acc_in = mm_p;
               if (mm_p == n_m1) begin
                  if (bi_ff == 4'(NumBases - 1)) begin
                     o_prime_in = 1'b1;
                     o_dec_in   = DecAllPass;
                     o_base_in  = 6'd0;
                     state_in   = StOut;
                  end else begin
                     bi_in    = bi_ff + 4'd1;
                     acc_in   = 64'd1;
                     bs_in    = {58'd0, base_at(bi_ff + 4'd1)};
                     sh_in    = d_ff;
                     state_in = StExpBit;
                  end
               end else if (k_ff + 7'd1 >= r_ff) begin
                  o_prime_in = 1'b0;
                  o_dec_in   = DecWitnessFails;
                  o_base_in  = cur_base;
                  state_in   = StOut;
               end else begin
                  k_in     = k_ff + 7'd1;
                  mm_start = 1'b1;
                  mm_x     = mm_p;
                  mm_y     = mm_p;
               end
            end
         end
         StOut: begin
            if (rsp_ready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      r_ff       <= r_in;
      k_ff       <= k_in;
      bi_ff      <= bi_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      bs_ff      <= bs_in;
      o_prime_ff <= o_prime_in;
      o_dec_ff   <= o_dec_in;
      o_base_ff  <= o_base_in;
   end

   assign req_ready         = (state_ff == StIdle);
   assign rsp_valid         = (state_ff == StOut);
   assign rsp_is_prime      = o_prime_ff;
   assign rsp_decided_by    = o_dec_ff;
   assign rsp_deciding_base = o_base_ff;
endmodule

FILE: rtl/mrpt_mulmod.sv
// Bit-serial modular multiplier (add-and-double), one multiplier bit a cycle.
// Depends on mrpt_pkg. Operands must already be reduced below the modulus.
`timescale 1ns / 1ps
module mrpt_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         op_x,
   input  logic [63:0]         op_y,
   input  logic [63:0]         modulus,
   output mrpt_pkg::mm_ctl_type ctl,
   output logic [63:0]         product
);
   import mrpt_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic [64:0] sum_acc, sum_dbl, sub_acc, sub_dbl;

   // 65-bit sums with one conditional subtract keep everything below the modulus
   assign sum_acc = {1'b0, acc_ff} + {1'b0, x_ff};
   assign sub_acc = sum_acc - {1'b0, modulus};
   assign sum_dbl = {x_ff, 1'b0};
   assign sub_dbl = sum_dbl - {1'b0, modulus};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = 64'd0;
         x_in    = op_x;
         y_in    = op_y;
      end else if (busy_ff) begin
         if (y_ff == 64'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff[0]) begin
               acc_in = sub_acc[64] ? sum_acc[63:0] : sub_acc[63:0];
            end
            x_in = sub_dbl[64] ? sum_dbl[63:0] : sub_dbl[63:0];
            y_in = {1'b0, y_ff[63:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign product   = acc_ff;
endmodule

FILE: bench/miller_rabin_prime_test_64_unit_tb.sv
// Testbench for miller_rabin_prime_test_64_unit: drives candidates over the req_ channel,
// predicts each verdict with a local Miller-Rabin model and checks every rsp_ transfer.
// Depends on mrpt_pkg and the unit's RTL.
`timescale 1ns / 1ps
module miller_rabin_prime_test_64_unit_tb;
   import mrpt_pkg::*;

   localparam int CycleLimit = 60000000;

   typedef struct packed {
      logic        is_prime;
      logic [2:0]  decided_by;
      logic [5:0]  deciding_base;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_is_prime;
   logic [2:0]  rsp_decided_by;
   logic [5:0]  rsp_deciding_base;

   verdict_type pending_verdicts[$];
   int          mismatches = 0;
   int          candidates_sent = 0;
   int          verdicts_seen = 0;
   int          primes_seen = 0;
   int          cycles = 0;
   bit          sender_idles = 1;
   bit          receiver_idles = 1;

   // Known 64-bit primes; they drive the full twelve-witness path.
   logic [63:0] known_primes[6] = '{64'd18446744073709551557, 64'd2305843009213693951,
                                    64'd1000000007, 64'd2147483647,
                                    64'd999999999989, 64'd4611686018427387847};

   miller_rabin_prime_test_64_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_number        (req_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_prime      (rsp_is_prime),
      .rsp_decided_by    (rsp_decided_by),
      .rsp_deciding_base (rsp_deciding_base)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Modular add at 65 bits so sums near 2^64 never wrap.
   function automatic logic [63:0] add_mod65(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[63:0];
   endfunction

   // Add-and-double modular product.
   function automatic logic [63:0] mul_mod64(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd0;
      x = x % m;
      while (y != 64'd0) begin
         if (y[0]) acc = add_mod65(acc, x, m);
         x = add_mod65(x, x, m);
         y = y >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] pow_mod64(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      b = b % m;
      while (e != 64'd0) begin
         if (e[0]) acc = mul_mod64(acc, b, m);
         b = mul_mod64(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Full verdict for one candidate: screen by the base table, then one round per base.
   function automatic verdict_type primality_verdict(logic [63:0] n);
      verdict_type v;
      logic [63:0] w;
      logic [63:0] d;
      logic [63:0] x;
      int          r;
      bit          passed;
      v = '0;
      if (n < 64'd2) begin
         v.decided_by = DecBelowTwo;
         return v;
      end
      for (int i = 0; i < NumBases; i++) begin
         w = 64'(base_at(4'(i)));
         if (n == w) begin
            v.is_prime = 1'b1;
            v.decided_by = DecEqualsBase;
            v.deciding_base = w[5:0];
            return v;
         end
         if (n % w == 64'd0) begin
            v.decided_by = DecBaseDivides;
            v.deciding_base = w[5:0];
            return v;
         end
      end
      d = n - 64'd1;
      r = 0;
      while (!d[0] && r < 64) begin
         d = d >> 1;
         r++;
      end
      for (int i = 0; i < NumBases; i++) begin
         w = 64'(base_at(4'(i)));
         x = pow_mod64(w, d, n);
         passed = (x == 64'd1) || (x == n - 64'd1);
         for (int k = 1; k < r && !passed; k++) begin
            x = mul_mod64(x, x, n);
            if (x == n - 64'd1) passed = 1'b1;
         end
         if (!passed) begin
            v.decided_by = DecWitnessFails;
            v.deciding_base = w[5:0];
            return v;
         end
      end
      v.is_prime = 1'b1;
      v.decided_by = DecAllPass;
      return v;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
   endtask

   // Offer one candidate, hold it until the transfer, then maybe drop valid for a burst.
   task automatic send_candidate(logic [63:0] n);
      req_valid <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (!req_ready);
      pending_verdicts.push_back(primality_verdict(n));
      candidates_sent++;
      if (sender_idles && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Extremes and every way a verdict can be reached.
   task automatic test_directed();
      logic [63:0] cases[$] = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd37, 64'd4, 64'd39,
                                64'd1369, 64'd41, 64'd1763, 64'd561, 64'd1373653,
                                64'd3215031751, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
                                64'd18446744073709551557, 64'd2305843009213693951};
      foreach (cases[i]) send_candidate(cases[i]);
   endtask

   // Random mix: wide noise, small values, known primes, multiples of known primes, odd numbers that pass the screen.
   task automatic test_random(int count);
      logic [63:0] n;
      logic [63:0] p;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1: n = {$urandom, $urandom};
            2: n = 64'($urandom_range(0, 200));
            3: n = known_primes[$urandom_range(0, 5)];
            4: begin
               p = known_primes[$urandom_range(2, 4)];
               n = p * 64'($urandom_range(3, 1000) | 1);
            end
            default: begin
               // Odd and not divisible by any base, so the rounds run.
               do n = {$urandom, $urandom} | 64'd1;
               while (n % 3 == 0 || n % 5 == 0 || n % 7 == 0 || n % 11 == 0 ||
                      n % 13 == 0 || n % 17 == 0 || n % 19 == 0 || n % 23 == 0 ||
                      n % 29 == 0 || n % 31 == 0 || n % 37 == 0);
            end
         endcase
         send_candidate(n);
      end
   endtask

   // Stall the receiver in random bursts while receiver_idles is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (!receiver_idles) begin
         rsp_ready <= 1'b1;
      end else if (rsp_ready && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_ready && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each verdict transfer with the oldest prediction.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("verdict with nothing pending, decided_by", rsp_decided_by, 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (want.is_prime) primes_seen++;
            if (rsp_is_prime !== want.is_prime)
               report_mismatch("is_prime", rsp_is_prime, want.is_prime);
            if (rsp_decided_by !== want.decided_by)
               report_mismatch("decided_by", rsp_decided_by, want.decided_by);
            if (rsp_deciding_base !== want.deciding_base)
               report_mismatch("deciding_base", rsp_deciding_base, want.deciding_base);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_number = 64'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      // Hold off until every verdict so far is back.
      wait_for_drain();
      test_random(70);
      // Run the tail with no sender pauses and the receiver always ready.
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      test_random(14);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d candidates, %0d verdicts, %0d of them prime",
               candidates_sent, verdicts_seen, primes_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end
endmodule
